// ----- src/assert_macros.svh -----
// Assertion helpers used by the RTL datapath. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_op;
    logic exec;
  } ctrl_cmd_t;

  // datapath -> each cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_cmd_t;

endpackage

// ----- src/spq_in_if.sv -----
`timescale 1ns / 1ps

interface spq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic signed [spq_pkg::PRIO_W-1:0] priority_req;
  logic [spq_pkg::DATA_W-1:0]       data;

  modport source (output valid, output action, output priority_req, output data,
                  input ready);
  modport sink   (input valid, input action, input priority_req, input data,
                  output ready);
endinterface

// ----- src/spq_out_if.sv -----
`timescale 1ns / 1ps

interface spq_out_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::DATA_W-1:0]   pop_data;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output pop_data, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_data, input status, input occupancy,
                  output ready);
endinterface

// ----- src/sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps

// Bounded priority queue of QUEUE_DEPTH entries kept sorted by ascending signed
// priority; entries of equal priority leave in arrival order. Each item is a
// push or a pop and yields one result: the popped payload (zero otherwise), a
// status (done, pop while empty, push while full) and the occupancy after the
// operation. An item is accepted in the idle state and executed in the
// execute state, in which every slot compares its key with the new one and
// shifts in parallel; no new item is taken until it has executed, and the
// execute state waits while the previous result is still held in the output
// register. Slot contents are not cleared at reset; only the entry count is.
module sorted_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_if,
  spq_out_if.source out_if
);

  spq_pkg::ctrl_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .cmd      (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_action      (in_if.action),
    .in_priority_req(in_if.priority_req),
    .in_data        (in_if.data),
    .out_pop_data   (out_if.pop_data),
    .out_status     (out_if.status),
    .out_occupancy  (out_if.occupancy)
  );

endmodule

// ----- src/spq_cell.sv -----
`timescale 1ns / 1ps

// One slot of the sorted array: compares its key against the new one and
// either holds, takes its left neighbor, takes the new entry or takes its
// right neighbor.
module spq_cell #(
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic                              clk,
  input  spq_pkg::cell_cmd_t                cmd,
  input  logic                              occupied,
  input  logic                              is_tail,
  input  logic signed [spq_pkg::PRIO_W-1:0] new_prio,
  input  logic [PAYLOAD_WIDTH-1:0]          new_payload,
  input  logic                              prev_gt,
  input  logic signed [spq_pkg::PRIO_W-1:0] prev_prio,
  input  logic [PAYLOAD_WIDTH-1:0]          prev_payload,
  input  logic signed [spq_pkg::PRIO_W-1:0] next_prio,
  input  logic [PAYLOAD_WIDTH-1:0]          next_payload,
  output logic                              gt,
  output logic signed [spq_pkg::PRIO_W-1:0] prio,
  output logic [PAYLOAD_WIDTH-1:0]          payload
);

  logic signed [spq_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [PAYLOAD_WIDTH-1:0]          payload_r, payload_nxt;

  // strictly greater: equal keys stay in front of the new item
  assign gt = occupied && (prio_r > new_prio);

  always_comb begin
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    if (cmd.push) begin
      if (prev_gt) begin
        prio_nxt    = prev_prio;
        payload_nxt = prev_payload;
      end else if (gt || is_tail) begin
        prio_nxt    = new_prio;
        payload_nxt = new_payload;
      end
    end else if (cmd.pop) begin
      prio_nxt    = next_prio;
      payload_nxt = next_payload;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

  assign prio    = prio_r;
  assign payload = payload_r;

endmodule

// ----- src/spq_ctrl.sv -----
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::ctrl_cmd_t cmd
);

  spq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load_op   = 1'b0;
    cmd.exec      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_nxt   = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        // result register must be free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/spq_datapath.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

module spq_datapath #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spq_pkg::ctrl_cmd_t                cmd,
  input  logic                              in_action,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [spq_pkg::DATA_W-1:0]        in_data,
  output logic [spq_pkg::DATA_W-1:0]        out_pop_data,
  output logic [spq_pkg::STATUS_W-1:0]      out_status,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // operation register
  logic                              op_action_r;
  logic signed [spq_pkg::PRIO_W-1:0] op_prio_r;
  logic [PAYLOAD_WIDTH-1:0]          op_payload_r;

  logic [CW-1:0] count_r, count_nxt;

  logic [spq_pkg::DATA_W-1:0]   pop_data_r;
  logic [spq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [spq_pkg::OCC_W-1:0]    occupancy_r;

  logic is_full, is_empty, push_ok, pop_ok;
  spq_pkg::cell_cmd_t cell_cmd;

  logic                              gt      [QUEUE_DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] prio    [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0]          payload [QUEUE_DEPTH];

  assign is_full  = (count_r == CW'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);
  assign push_ok  = cmd.exec && (op_action_r == spq_pkg::ACT_PUSH) && !is_full;
  assign pop_ok   = cmd.exec && (op_action_r == spq_pkg::ACT_POP) && !is_empty;

  assign cell_cmd.push = push_ok;
  assign cell_cmd.pop  = pop_ok;

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_action_r  <= in_action;
      op_prio_r    <= in_priority_req;
      op_payload_r <= PAYLOAD_WIDTH'(in_data);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                              prev_gt_w;
    logic signed [spq_pkg::PRIO_W-1:0] prev_prio_w, next_prio_w;
    logic [PAYLOAD_WIDTH-1:0]          prev_payload_w, next_payload_w;

    if (i == 0) begin : g_head
      assign prev_gt_w      = 1'b0;
      assign prev_prio_w    = '0;
      assign prev_payload_w = '0;
    end else begin : g_body
      assign prev_gt_w      = gt[i-1];
      assign prev_prio_w    = prio[i-1];
      assign prev_payload_w = payload[i-1];
    end

    // last slot keeps its value on a pop; it falls out of range anyway
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_prio_w    = prio[i];
      assign next_payload_w = payload[i];
    end else begin : g_mid
      assign next_prio_w    = prio[i+1];
      assign next_payload_w = payload[i+1];
    end

    spq_cell #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .occupied    (CW'(i) < count_r),
      .is_tail     (CW'(i) == count_r),
      .new_prio    (op_prio_r),
      .new_payload (op_payload_r),
      .prev_gt     (prev_gt_w),
      .prev_prio   (prev_prio_w),
      .prev_payload(prev_payload_w),
      .next_prio   (next_prio_w),
      .next_payload(next_payload_w),
      .gt          (gt[i]),
      .prio        (prio[i]),
      .payload     (payload[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::STATUS_DONE;
    if (push_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok) begin
      count_nxt = count_r - 1'b1;
    end else if (op_action_r == spq_pkg::ACT_PUSH) begin
      status_nxt = spq_pkg::STATUS_FULL;
    end else begin
      status_nxt = spq_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pop_data_r  <= pop_ok ? spq_pkg::DATA_W'(payload[0]) : '0;
      status_r    <= status_nxt;
      occupancy_r <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_pop_data  = pop_data_r;
  assign out_status    = status_r;
  assign out_occupancy = occupancy_r;

  `SPQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(QUEUE_DEPTH), "entry count over depth")
  `SPQ_ASSERT_NEXT(a_count_hold, clk, rst_n, !cmd.exec, $stable(count_r), "count moved while idle")
  `SPQ_ASSERT(a_head_sorted, clk, rst_n, (count_r < CW'(2)) || (prio[0] <= prio[1]), "head out of order")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned N_RANDOM = 1000;
  localparam int unsigned HOLD_OFF_CYCLES = 250;

  typedef struct packed {
    logic [spq_pkg::DATA_W-1:0]   pop_data;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::OCC_W-1:0]    occupancy;
  } result_t;

  typedef struct {
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::DATA_W-1:0]        payload;
  } entry_t;

  typedef struct {
    logic                              action;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::DATA_W-1:0]        data;
    bit                                typed;
    result_t                           res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_if ();
  spq_out_if out_if ();

  sorted_priority_queue_core #(
    .QUEUE_DEPTH  (DEPTH),
    .PAYLOAD_WIDTH(spq_pkg::DATA_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always #5 clk = ~clk;

  // predictor state and the results still owed by the block
  entry_t    sorted_entries[$];
  result_t   pending_results[$];
  stim_row_t directed_rows[$];

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned n_pop_data, n_pop_empty, n_push_full;
  int unsigned peak_occupancy;
  int unsigned burst_left;
  logic        hold_off;

  function automatic result_t apply_queue_op(logic act,
                                             logic signed [spq_pkg::PRIO_W-1:0] prio,
                                             logic [spq_pkg::DATA_W-1:0] data);
    result_t r;
    entry_t  e;
    int      pos;
    r = '0;
    if (act == spq_pkg::ACT_PUSH) begin
      if (sorted_entries.size() >= DEPTH) begin
        r.status = spq_pkg::STATUS_FULL;
      end else begin
        // new entry goes behind every entry of equal priority
        pos = sorted_entries.size();
        for (int i = 0; i < sorted_entries.size(); i++) begin
          if (sorted_entries[i].prio > prio) begin
            pos = i;
            break;
          end
        end
        e.prio = prio;
        e.payload = data;
        sorted_entries.insert(pos, e);
        r.status = spq_pkg::STATUS_DONE;
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        r.status = spq_pkg::STATUS_EMPTY;
      end else begin
        e = sorted_entries.pop_front();
        r.pop_data = e.payload;
        r.status = spq_pkg::STATUS_DONE;
      end
    end
    r.occupancy = spq_pkg::OCC_W'(sorted_entries.size());
    return r;
  endfunction

  function automatic void add_row(logic act, logic signed [spq_pkg::PRIO_W-1:0] prio,
                                  logic [spq_pkg::DATA_W-1:0] data, bit typed,
                                  logic [spq_pkg::DATA_W-1:0] pd,
                                  logic [spq_pkg::STATUS_W-1:0] st,
                                  logic [spq_pkg::OCC_W-1:0] occ);
    stim_row_t row;
    row.action = act;
    row.prio = prio;
    row.data = data;
    row.typed = typed;
    row.res.pop_data = pd;
    row.res.status = st;
    row.res.occupancy = occ;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed_rows();
    add_row(spq_pkg::ACT_POP, 32'sh0, 32'h0, 1'b1, 32'h0, spq_pkg::STATUS_EMPTY, 5'd0);
    add_row(spq_pkg::ACT_PUSH, 32'sh7fff_ffff, 32'hffff_ffff, 1'b1, 32'h0,
            spq_pkg::STATUS_DONE, 5'd1);
    add_row(spq_pkg::ACT_PUSH, 32'sh8000_0000, 32'h0000_0000, 1'b1, 32'h0,
            spq_pkg::STATUS_DONE, 5'd2);
    // three of equal priority, must leave in arrival order
    add_row(spq_pkg::ACT_PUSH, 32'sh0, 32'h1111_1111, 1'b1, 32'h0,
            spq_pkg::STATUS_DONE, 5'd3);
    add_row(spq_pkg::ACT_PUSH, 32'sh0, 32'h2222_2222, 1'b1, 32'h0,
            spq_pkg::STATUS_DONE, 5'd4);
    add_row(spq_pkg::ACT_PUSH, 32'sh0, 32'h3333_3333, 1'b1, 32'h0,
            spq_pkg::STATUS_DONE, 5'd5);
    add_row(spq_pkg::ACT_PUSH, -32'sd1, 32'haaaa_5555, 1'b1, 32'h0,
            spq_pkg::STATUS_DONE, 5'd6);
    add_row(spq_pkg::ACT_PUSH, 32'sd1, 32'h5555_aaaa, 1'b1, 32'h0,
            spq_pkg::STATUS_DONE, 5'd7);
    for (int i = 0; i < 9; i++)
      add_row(spq_pkg::ACT_PUSH, spq_pkg::PRIO_W'(i * 1000 - 4000), 32'hc0de_0000 + i,
              1'b1, 32'h0, spq_pkg::STATUS_DONE, spq_pkg::OCC_W'(8 + i));
    add_row(spq_pkg::ACT_PUSH, 32'sh8000_0000, 32'hdead_beef, 1'b1, 32'h0,
            spq_pkg::STATUS_FULL, 5'd16);
    // pops: fields on a pop are don't-care, drive them hard
    add_row(spq_pkg::ACT_POP, 32'sh7fff_ffff, 32'hffff_ffff, 1'b0, '0, '0, '0);
    add_row(spq_pkg::ACT_POP, 32'sh8000_0000, 32'h0, 1'b0, '0, '0, '0);
    for (int i = 0; i < 4; i++)
      add_row(spq_pkg::ACT_POP, 32'sh1234_5678, 32'h8765_4321, 1'b0, '0, '0, '0);
    add_row(spq_pkg::ACT_PUSH, 32'sh0, 32'h4444_4444, 1'b0, '0, '0, '0);
  endfunction

  // one item on the input channel, then the sender's burst/gap pattern
  task automatic send_item(logic act, logic signed [spq_pkg::PRIO_W-1:0] prio,
                           logic [spq_pkg::DATA_W-1:0] data, bit typed,
                           result_t typed_res);
    result_t r;
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.priority_req <= prio;
    in_if.data <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    r = apply_queue_op(act, prio, data);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
    if (burst_left <= 1) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return spq_pkg::PRIO_W'($signed($urandom_range(0, 6)) - 3);
    if (sel < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom);
  endfunction

  // stimulus
  initial begin
    int unsigned seg_left;
    int unsigned push_pct;
    result_t     no_res;
    no_res = '0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.action <= spq_pkg::ACT_PUSH;
    in_if.priority_req <= '0;
    in_if.data <= '0;
    burst_left = 5;
    seg_left = 0;
    push_pct = 50;
    build_directed_rows();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].action, directed_rows[i].prio, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].res);

    // segments that lean toward filling, draining or neither, so full and empty recur
    for (int n = 0; n < N_RANDOM; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      seg_left--;
      send_item(($urandom_range(0, 99) < push_pct) ? spq_pkg::ACT_PUSH : spq_pkg::ACT_POP,
                pick_priority(), $urandom, 1'b0, no_res);
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb_top: %0d items, %0d pops returned data, %0d pops on empty, %0d pushes on full",
             items_sent, n_pop_data, n_pop_empty, n_push_full);
    $display("tb_top: peak occupancy %0d of %0d, %0d results checked",
             peak_occupancy, DEPTH, results_seen);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // receiver: stall pattern chosen by bits 8:6 of the cycle counter, forced low during a hold-off
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (!rst_n || hold_off) begin
        out_if.ready <= 1'b0;
      end else begin
        case (rx_cycle[8:6])
          0, 1: out_if.ready <= 1'b1;
          2: out_if.ready <= rx_cycle[0];
          3: out_if.ready <= (rx_cycle[1:0] == 2'd0);
          4, 5: out_if.ready <= ($urandom_range(0, 3) != 0);
          6: out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= (rx_cycle[2:0] != 3'd7);
        endcase
      end
    end
  end

  // long hold-off so the queue backs up and the input stalls
  initial begin
    hold_off <= 1'b0;
    wait (results_seen >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.status == spq_pkg::STATUS_EMPTY) n_pop_empty++;
      if (out_if.status == spq_pkg::STATUS_FULL) n_push_full++;
      if (out_if.status == spq_pkg::STATUS_DONE && out_if.pop_data != 0) n_pop_data++;
      if (int'(out_if.occupancy) > peak_occupancy) peak_occupancy = int'(out_if.occupancy);
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: pop_data %h status %0d occupancy %0d",
               out_if.pop_data, out_if.status, out_if.occupancy);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.pop_data !== want.pop_data) begin
          $error("pop_data expected %h actual %h", want.pop_data, out_if.pop_data);
          fail_count++;
        end
        if (out_if.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_if.status);
          fail_count++;
        end
        if (out_if.occupancy !== want.occupancy) begin
          $error("occupancy expected %0d actual %0d", want.occupancy, out_if.occupancy);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/spq_pkg.sv
src/spq_in_if.sv
src/spq_out_if.sv
src/spq_cell.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/sorted_priority_queue_core.sv
sim/tb_top.sv
